FILE: rtl/srsw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the selective-repeat send window.
// No dependencies; used by every module of the block.
package srsw_pkg;

  localparam int unsigned MaxSlotsDefault = 16;
  localparam longint unsigned SeqModulus = 64'd65536;
  localparam longint unsigned PayloadBytes = 64'd1024;

  // Residue of the byte offset modulo the sequence modulus.
  localparam int unsigned ResW = 33;
  localparam logic [ResW-1:0] SeqMod = ResW'(SeqModulus);
  localparam logic [ResW-1:0] PayMod = ResW'(PayloadBytes % SeqModulus);
  localparam logic [15:0] PayLen = 16'(PayloadBytes);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_RETX  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ANNOUNCE = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_REQ      = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_COMPLETE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_DATA  = 2'd1,
    MARK_ACKED = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    REG_FILE_SIZE = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_TIMEOUT   = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_EXEC,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    PH_BASE_FIRST,
    PH_BASE_LOOP,
    PH_SCAN
  } phase_e;

  // One window slot as stored in the slot memory.
  typedef struct packed {
    logic [15:0] seq;
    mark_e       mark;
    logic [31:0] offset;
    logic [10:0] len;
    logic [31:0] stamp;
  } slot_t;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [15:0] seq;
    logic [31:0] offset;
    logic [10:0] len;
  } result_t;

  // Result produced by the sequencer in one cycle, plus end-of-item flush.
  typedef struct packed {
    logic    valid;
    logic    flush;
    result_t res;
  } emit_t;

endpackage

FILE: rtl/srsw_slot_mem.sv
`timescale 1ns / 1ps
// Slot memory: one write port, one registered read port, per-entry valid bits.
// Depends on srsw_pkg.
module srsw_slot_mem #(
  parameter int unsigned MaxSlots = srsw_pkg::MaxSlotsDefault,
  parameter int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 we_i,
  input  logic [IdxW-1:0]      waddr_i,
  input  srsw_pkg::slot_t      wdata_i,
  input  logic [IdxW-1:0]      raddr_i,
  output srsw_pkg::slot_t      rdata_o
);
  import srsw_pkg::*;

  slot_t                mem [MaxSlots];
  logic [MaxSlots-1:0]  valid_q;
  slot_t                rdata_q;
  logic                 rvalid_q;

  // Storage array and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // Valid bits: an entry never written since reset or start reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[raddr_i];
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  always_comb begin
    rdata_o = rdata_q;
    if (!rvalid_q) begin
      rdata_o.mark = MARK_EMPTY;
    end
  end

endmodule

FILE: rtl/srsw_out_buf.sv
`timescale 1ns / 1ps
// Result holding stage: keeps one result back so the final one carries last.
// Depends on srsw_pkg.
module srsw_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srsw_pkg::emit_t   emit_i,
  output logic              strobe_o,
  output logic [2:0]        kind_o,
  output logic [3:0]        slot_o,
  output logic [15:0]       out_seq_o,
  output logic [31:0]       byte_offset_o,
  output logic [10:0]       length_o,
  output logic              last_o
);
  import srsw_pkg::*;

  logic    pend_v_q;
  result_t pend_q;
  logic    strobe_q;
  logic    last_q;
  result_t out_q;

  // Control: a held result leaves when a newer one arrives or the item ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= pend_v_q & (emit_i.valid | emit_i.flush);
      last_q   <= emit_i.flush;
      if (emit_i.valid) begin
        pend_v_q <= 1'b1;
      end else if (emit_i.flush) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    out_q <= pend_q;
    if (emit_i.valid) begin
      pend_q <= emit_i.res;
    end
  end

  assign strobe_o      = strobe_q;
  assign kind_o        = out_q.kind;
  assign slot_o        = out_q.slot;
  assign out_seq_o     = out_q.seq;
  assign byte_offset_o = out_q.offset;
  assign length_o      = out_q.len;
  assign last_o        = last_q;

endmodule

FILE: rtl/selective_repeat_send_window_top.sv
`timescale 1ns / 1ps
// Top level of the selective-repeat send window: sequencer and window state.
// Depends on srsw_pkg, srsw_slot_mem and srsw_out_buf.
//
// An item is taken when start_i is high and busy_o is low. Results appear one
// per cycle on strobe_o and cannot be held off; last_o marks the final result
// of an item. Each item passes an accept state and a closing flush state; in
// between, a start loads one chunk per cycle (up to the slot count), a tick or
// retransmit request visits every window slot, and an acknowledgement visits
// slots starting from the base. Each slot visit is the read of the slot memory
// (ST_READ) followed by its modify and write back (ST_EXEC). A result is held
// in the output buffer until it is known whether another follows, and is then
// registered onto the outputs.
module selective_repeat_send_window_top #(
  parameter int unsigned MaxSlots = srsw_pkg::MaxSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] seq_i,
  input  logic [10:0] ack_len_i,
  output logic        strobe_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [15:0] out_seq_o,
  output logic [31:0] byte_offset_o,
  output logic [10:0] length_o,
  output logic        last_o
);
  import srsw_pkg::*;

  localparam int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CntW = $clog2(MaxSlots + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxSlots);

  // Configuration registers.
  logic [31:0] file_size_q;
  logic [4:0]  window_slots_q;
  logic [15:0] timeout_q;

  // Window state and sequencer registers.
  state_e          state_q, state_d;
  phase_e          phase_q, phase_d;
  cmd_e            cmd_q, cmd_d;
  logic [15:0]     seq_q, seq_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] base_q, base_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] w_q, w_d;
  logic [31:0]     next_off_q, next_off_d;
  logic [ResW-1:0] res_q, res_d;
  logic [31:0]     acked_q, acked_d;
  logic [31:0]     now_q, now_d;
  logic            fin_q, fin_d;
  logic            started_q, started_d;

  // Memory and output signals.
  logic            mem_clear, mem_we;
  logic [IdxW-1:0] mem_waddr;
  slot_t           mem_wdata, rd;
  emit_t           emit;

  // Chunk arithmetic for the next load.
  logic            ended;
  logic [31:0]     remain;
  logic [15:0]     chunk_len;
  logic [31:0]     off_after;
  logic [ResW:0]   res_sum;
  logic [ResW-1:0] res_next;
  logic [CntW-1:0] clamp_w;
  logic [4:0]      ws_nz;
  logic            accept;
  logic            match;
  logic            stale;
  logic [IdxW-1:0] idx_inc;
  logic [31:0]     acked_sum;
  slot_t           chunk;

  assign accept = start_i & (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // The residue advances by the length actually loaded, so it follows the offset.
  assign ended     = (next_off_q >= file_size_q);
  assign remain    = ended ? 32'd0 : (file_size_q - next_off_q);
  assign chunk_len = (remain < {16'd0, PayLen}) ? remain[15:0] : PayLen;
  assign off_after = next_off_q + {16'd0, chunk_len};
  assign res_sum   = {1'b0, res_q} + {{(ResW-15){1'b0}}, chunk_len};
  assign res_next  = (res_sum >= {1'b0, SeqMod}) ? ResW'(res_sum - {1'b0, SeqMod})
                                                 : res_sum[ResW-1:0];
  assign ws_nz     = (window_slots_q == 5'd0) ? 5'd1 : window_slots_q;
  assign clamp_w   = ({27'd0, ws_nz} > MaxSlots) ? MaxCnt : CntW'(ws_nz);
  assign match     = (rd.mark != MARK_EMPTY) && (rd.seq == seq_q);
  assign stale     = (rd.mark == MARK_DATA) && ((now_q - rd.stamp) > {16'd0, timeout_q});
  assign idx_inc   = ({1'b0, idx_q} + 1'b1 == (IdxW+1)'(w_q)) ? '0 : idx_q + 1'b1;
  assign acked_sum = acked_q + {21'd0, ack_len_i};

  always_comb begin
    chunk.seq    = res_q[15:0];
    chunk.mark   = MARK_DATA;
    chunk.offset = next_off_q;
    chunk.len    = chunk_len[10:0];
    chunk.stamp  = now_q;
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q    <= '0;
      window_slots_q <= 5'd16;
      timeout_q      <= 16'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FILE_SIZE: file_size_q    <= cfg_wdata_i;
        REG_WINDOW:    window_slots_q <= cfg_wdata_i[4:0];
        REG_TIMEOUT:   timeout_q      <= cfg_wdata_i[15:0];
        default:       ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_START: state_d = ST_START;
            CMD_TICK:  state_d = (started_q && !fin_q) ? ST_READ : ST_FLUSH;
            CMD_RETX:  state_d = (started_q && !fin_q) ? ST_READ : ST_FLUSH;
            default: begin
              if (!started_q || fin_q || acked_sum == file_size_q) begin
                state_d = ST_FLUSH;
              end else begin
                state_d = ST_READ;
              end
            end
          endcase
        end
      end
      ST_START: begin
        if (off_after >= file_size_q || {1'b0, idx_q} + 1'b1 == (IdxW+1)'(w_q)) begin
          state_d = ST_FLUSH;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        state_d = ST_READ;
        unique case (cmd_q)
          CMD_TICK, CMD_RETX: begin
            if (idx_inc == '0) state_d = ST_FLUSH;
          end
          default: begin
            unique case (phase_q)
              PH_BASE_FIRST, PH_BASE_LOOP: begin
                if (phase_q == PH_BASE_FIRST && !match) begin
                  if (w_q == CntW'(1)) state_d = ST_FLUSH;
                end else if (!(match || rd.mark == MARK_ACKED) || ended ||
                             cnt_q + 1'b1 == w_q) begin
                  state_d = ST_FLUSH;
                end
              end
              default: begin
                if (match || idx_inc == base_q) state_d = ST_FLUSH;
              end
            endcase
          end
        endcase
      end
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath updates, memory writes and results.
  always_comb begin
    phase_d    = phase_q;
    cmd_d      = cmd_q;
    seq_d      = seq_q;
    idx_d      = idx_q;
    base_d     = base_q;
    cnt_d      = cnt_q;
    w_d        = w_q;
    next_off_d = next_off_q;
    res_d      = res_q;
    acked_d    = acked_q;
    now_d      = now_q;
    fin_d      = fin_q;
    started_d  = started_q;
    mem_clear  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = rd;
    emit       = '0;
    emit.res.kind   = KIND_DATA;
    emit.res.slot   = 4'(idx_q);
    emit.res.seq    = rd.seq;
    emit.res.offset = rd.offset;
    emit.res.len    = rd.len;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_e'(command_i);
          seq_d = seq_i;
          idx_d = '0;
          cnt_d = '0;
          unique case (command_i)
            CMD_START: begin
              w_d        = clamp_w;
              mem_clear  = 1'b1;
              base_d     = '0;
              next_off_d = '0;
              res_d      = '0;
              acked_d    = '0;
              fin_d      = 1'b0;
              started_d  = 1'b1;
              emit.valid      = 1'b1;
              emit.res.kind   = KIND_ANNOUNCE;
              emit.res.slot   = '0;
              emit.res.seq    = '0;
              emit.res.offset = file_size_q;
              emit.res.len    = 11'(clamp_w);
            end
            CMD_TICK: now_d = now_q + 32'd1;
            CMD_RETX: ;
            default: begin
              if (started_q && !fin_q) begin
                acked_d = acked_sum;
                idx_d   = base_q;
                phase_d = PH_BASE_FIRST;
                if (acked_sum == file_size_q) begin
                  fin_d           = 1'b1;
                  emit.valid      = 1'b1;
                  emit.res.kind   = KIND_COMPLETE;
                  emit.res.slot   = '0;
                  emit.res.seq    = '0;
                  emit.res.offset = acked_sum;
                  emit.res.len    = '0;
                end
              end
            end
          endcase
        end
      end
      ST_START: begin
        // Load and send one chunk per cycle.
        mem_we          = 1'b1;
        mem_wdata       = chunk;
        emit.valid      = 1'b1;
        emit.res.seq    = chunk.seq;
        emit.res.offset = chunk.offset;
        emit.res.len    = chunk.len;
        next_off_d      = off_after;
        res_d           = res_next;
        idx_d           = idx_q + 1'b1;
      end
      ST_EXEC: begin
        unique case (cmd_q)
          CMD_TICK, CMD_RETX: begin
            if ((cmd_q == CMD_TICK) ? stale : match) begin
              mem_we          = 1'b1;
              mem_wdata.stamp = now_q;
              emit.valid      = 1'b1;
              emit.res.kind   = (cmd_q == CMD_TICK) ? KIND_TIMEOUT : KIND_REQ;
            end
            idx_d = idx_inc;
          end
          default: begin
            unique case (phase_q)
              PH_BASE_FIRST, PH_BASE_LOOP: begin
                if (phase_q == PH_BASE_FIRST && !match) begin
                  // Acknowledgement for another slot: scan from after the base.
                  phase_d = PH_SCAN;
                  idx_d   = idx_inc;
                end else if (match || rd.mark == MARK_ACKED) begin
                  if (ended) begin
                    mem_we         = 1'b1;
                    mem_wdata.mark = MARK_ACKED;
                  end else begin
                    mem_we          = 1'b1;
                    mem_wdata       = chunk;
                    emit.valid      = 1'b1;
                    emit.res.seq    = chunk.seq;
                    emit.res.offset = chunk.offset;
                    emit.res.len    = chunk.len;
                    next_off_d      = off_after;
                    res_d           = res_next;
                    base_d          = idx_inc;
                    idx_d           = idx_inc;
                    cnt_d           = cnt_q + 1'b1;
                    phase_d         = PH_BASE_LOOP;
                  end
                end
              end
              default: begin
                if (match) begin
                  mem_we         = 1'b1;
                  mem_wdata.mark = MARK_ACKED;
                end
                idx_d = idx_inc;
              end
            endcase
          end
        endcase
      end
      ST_FLUSH: emit.flush = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_BASE_FIRST;
      cmd_q      <= CMD_START;
      idx_q      <= '0;
      base_q     <= '0;
      cnt_q      <= '0;
      w_q        <= MaxCnt;
      next_off_q <= '0;
      res_q      <= '0;
      acked_q    <= '0;
      now_q      <= '0;
      fin_q      <= 1'b0;
      started_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      cmd_q      <= cmd_d;
      idx_q      <= idx_d;
      base_q     <= base_d;
      cnt_q      <= cnt_d;
      w_q        <= w_d;
      next_off_q <= next_off_d;
      res_q      <= res_d;
      acked_q    <= acked_d;
      now_q      <= now_d;
      fin_q      <= fin_d;
      started_q  <= started_d;
    end
  end

  // Input sequence number of the item in progress.
  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
  end

  srsw_slot_mem #(
    .MaxSlots (MaxSlots),
    .IdxW     (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (mem_clear),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (rd)
  );

  srsw_out_buf u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit),
    .strobe_o      (strobe_o),
    .kind_o        (kind_o),
    .slot_o        (slot_o),
    .out_seq_o     (out_seq_o),
    .byte_offset_o (byte_offset_o),
    .length_o      (length_o),
    .last_o        (last_o)
  );

endmodule
